>>> rtl/utf_pkg.sv
// shared constants, result structs and the month table for the fat timestamp converter
`timescale 1ns / 1ps

package utf_pkg;

	// 1980-01-01 00:00:00 in unix seconds
	localparam logic [31:0] FAT_EPOCH_SECS = 32'd315532800;

	// seconds per day, per hour slice and per minute
	localparam logic [16:0] DAY_SECS = 17'd86400;
	localparam logic [11:0] HOUR_SECS = 12'd3600;
	localparam logic [5:0] MIN_SECS = 6'd60;

	// days = ((since >> 7) * DAY_RECIP) >> 35, exact for every 32-bit since
	localparam logic [25:0] DAY_RECIP = 26'd50903317;

	// quad = (days * QUAD_RECIP) >> 27, exact below 2^16 days
	localparam logic [16:0] QUAD_RECIP = 17'd91868;
	localparam logic [10:0] QUAD_DAYS = 11'd1461;

	// hour = ((sod >> 4) * HOUR_RECIP) >> 20, exact below one day
	localparam logic [12:0] HOUR_RECIP = 13'd4661;

	// minute of day = ((sod >> 2) * MOD_RECIP) >> 18, exact below one day
	localparam logic [14:0] MOD_RECIP = 15'd17477;

	// first day of 2100-03-01 counted from 1980; a dummy feb 29 is slipped in here
	localparam logic [15:0] LEAP_FIX_DAY = 16'd43889;

	// start of years two, three and four inside a leap-first four-year block
	localparam logic [10:0] YEAR1_START = 11'd366;
	localparam logic [10:0] YEAR2_START = 11'd731;
	localparam logic [10:0] YEAR3_START = 11'd1096;

	// cumulative days before each month in a common year
	localparam logic [8:0] MONTH_START [13] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
	};

	typedef struct packed {
		logic [6:0] year_off;
		logic [3:0] month;
		logic [4:0] mday;
	} utf_date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [4:0] sec2;
	} utf_tod_t;

	// first day of year of month index idx (0 = january), one later from march in leap years
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic bump;
		bump = leap && (idx >= 4'd2);
		return MONTH_START[idx] + 9'(bump);
	endfunction

endpackage

>>> rtl/utf_date.sv
// day count since 1980 to years since 1980, month and day of month, three stages
`timescale 1ns / 1ps

module utf_date (
	input  logic               clk,
	input  logic [15:0]        days,
	output utf_pkg::utf_date_t date
);
	import utf_pkg::*;

	logic [15:0] dadj;
	logic [32:0] quad_prod;
	logic [4:0]  quad_c;

	logic [15:0] dadj_s3;
	logic [4:0]  quad_s3;

	logic [15:0] quad_days;
	logic [15:0] rq_full;
	logic [10:0] rq;
	logic [1:0]  yq;
	logic [10:0] ybase;
	logic [10:0] doy_full;

	logic [6:0]  year_off_s4;
	logic [8:0]  doy_s4;
	logic        leap_s4;

	logic [3:0]  mcount;
	logic [3:0]  month_c;
	logic [8:0]  mday_full;

	utf_date_t   date_s5;

	// skip the missing feb 29 of 2100 so every fourth year is leap, then split by 1461
	assign dadj = days + 16'(days >= LEAP_FIX_DAY);
	assign quad_prod = 33'(dadj) * 33'(QUAD_RECIP);
	assign quad_c = quad_prod[31:27];

	always_ff @(posedge clk) begin
		dadj_s3 <= dadj;
		quad_s3 <= quad_c;
	end

	// day inside the four-year block, then year inside it
	assign quad_days = 16'(quad_s3) * 16'(QUAD_DAYS);
	assign rq_full = dadj_s3 - quad_days;
	assign rq = rq_full[10:0];

	always_comb begin
		if (rq >= YEAR3_START) begin
			yq = 2'd3;
			ybase = YEAR3_START;
		end else if (rq >= YEAR2_START) begin
			yq = 2'd2;
			ybase = YEAR2_START;
		end else if (rq >= YEAR1_START) begin
			yq = 2'd1;
			ybase = YEAR1_START;
		end else begin
			yq = 2'd0;
			ybase = 11'd0;
		end
	end

	assign doy_full = rq - ybase;

	always_ff @(posedge clk) begin
		year_off_s4 <= {quad_s3, yq};
		doy_s4 <= doy_full[8:0];
		leap_s4 <= (yq == 2'd0);
	end

	// month is one plus the number of later month starts already reached
	always_comb begin
		mcount = 4'd0;
		for (int m = 1; m < 12; m++) begin
			mcount = mcount + 4'(doy_s4 >= month_start(4'(m), leap_s4));
		end
	end

	assign month_c = mcount + 4'd1;
	assign mday_full = doy_s4 - month_start(mcount, leap_s4) + 9'd1;

	always_ff @(posedge clk) begin
		date_s5.year_off <= year_off_s4;
		date_s5.month <= month_c;
		date_s5.mday <= mday_full[4:0];
	end

	assign date = date_s5;

endmodule

>>> rtl/utf_clock.sv
// seconds of the day to hour, minute and halved second, three stages
`timescale 1ns / 1ps

module utf_clock (
	input  logic              clk,
	input  logic [31:0]       since,
	input  logic [15:0]       days,
	output utf_pkg::utf_tod_t tod
);
	import utf_pkg::*;

	logic [31:0] day_base;
	logic [31:0] sod_full;

	logic [16:0] sod_s3;

	logic [25:0] hour_prod;
	logic [29:0] mod_prod;

	logic [4:0]  hour_s4;
	logic [10:0] mod_s4;
	logic [16:0] sod_s4;

	logic [10:0] hour_mins;
	logic [10:0] minute_full;
	logic [16:0] mod_secs;
	logic [16:0] sec_full;

	utf_tod_t    tod_s5;

	// seconds left over after the whole days
	assign day_base = 32'(days) * 32'(DAY_SECS);
	assign sod_full = since - day_base;

	always_ff @(posedge clk) begin
		sod_s3 <= sod_full[16:0];
	end

	// hour and minute of day side by side
	assign hour_prod = 26'(sod_s3[16:4]) * 26'(HOUR_RECIP);
	assign mod_prod = 30'(sod_s3[16:2]) * 30'(MOD_RECIP);

	always_ff @(posedge clk) begin
		hour_s4 <= hour_prod[24:20];
		mod_s4 <= mod_prod[28:18];
		sod_s4 <= sod_s3;
	end

	// minute within the hour and second within the minute
	assign hour_mins = 11'(hour_s4) * 11'(MIN_SECS);
	assign minute_full = mod_s4 - hour_mins;
	assign mod_secs = 17'(mod_s4) * 17'(MIN_SECS);
	assign sec_full = sod_s4 - mod_secs;

	always_ff @(posedge clk) begin
		tod_s5.hour <= hour_s4;
		tod_s5.minute <= minute_full[5:0];
		tod_s5.sec2 <= sec_full[5:1];
	end

	assign tod = tod_s5;

endmodule

>>> rtl/unix_to_fat_timestamp_top.sv
// unix seconds to packed fat date-time word, six-stage pipeline
//
// channel  | ports                           | handshake
// ---------+---------------------------------+------------------------------
// input    | unix_seconds                    | taken when start && !busy
// result   | fat_datetime, before_epoch      | done high for one cycle
//
// one item is taken every cycle; busy stays low
// done rises together with the registered result word, after the item has passed valid_s1 through valid_s5
// the depth comes from the chain of constant-reciprocal multiplies
// (days, four-year block, hour) each followed by its remainder step
// reset clears the valid chain and done; the receiver cannot stall
`timescale 1ns / 1ps

module unix_to_fat_timestamp_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] unix_seconds,
	output logic        done,
	output logic [31:0] fat_datetime,
	output logic        before_epoch
);
	import utf_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [31:0] secs_s1;

	logic        before_c;
	logic [31:0] since_c;
	logic [50:0] day_prod;

	logic [15:0] days_s2;
	logic [31:0] since_s2;
	logic        before_s2, before_s3, before_s4, before_s5;

	utf_date_t   date_s5;
	utf_tod_t    tod_s5;
	logic [31:0] word_c;

	logic        done_q;
	logic [31:0] fat_datetime_q;
	logic        before_epoch_q;

	assign busy = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q <= valid_s5;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			secs_s1 <= unix_seconds;
		end
	end

	// offset to 1980 and whole days by reciprocal of 675 after dropping 7 bits
	assign before_c = secs_s1 < FAT_EPOCH_SECS;
	assign since_c = secs_s1 - FAT_EPOCH_SECS;
	assign day_prod = 51'(since_c[31:7]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		days_s2 <= day_prod[50:35];
		since_s2 <= since_c;
		before_s2 <= before_c;
		before_s3 <= before_s2;
		before_s4 <= before_s3;
		before_s5 <= before_s4;
	end

	// calendar date and time of day in parallel
	utf_date u_date (
		.clk  (clk),
		.days (days_s2),
		.date (date_s5)
	);

	utf_clock u_clock (
		.clk   (clk),
		.since (since_s2),
		.days  (days_s2),
		.tod   (tod_s5)
	);

	// pack the word, zero before 1980
	assign word_c = before_s5 ? 32'd0 :
		{date_s5.year_off, date_s5.month, date_s5.mday,
		 tod_s5.hour, tod_s5.minute, tod_s5.sec2};

	always_ff @(posedge clk) begin
		fat_datetime_q <= word_c;
		before_epoch_q <= before_s5;
	end

	assign done = done_q;
	assign fat_datetime = fat_datetime_q;
	assign before_epoch = before_epoch_q;

	// every taken item comes out with done once it has passed the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##5 done)
		else $error("result strobe missing six cycles after an item");

	// early inputs give an all-zero word
	a_before_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && before_epoch) |-> (fat_datetime == 32'd0))
		else $error("word not zero for a time before 1980");

	// month stays in 1 to 12 and day of month is nonzero
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !before_epoch) |-> ((fat_datetime[24:21] != 4'd0) &&
		(fat_datetime[24:21] <= 4'd12) && (fat_datetime[20:16] != 5'd0)))
		else $error("month or day out of range");

	// time fields stay in clock range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !before_epoch) |-> ((fat_datetime[15:11] <= 5'd23) &&
		(fat_datetime[10:5] <= 6'd59) && (fat_datetime[4:0] <= 5'd29)))
		else $error("hour, minute or second out of range");

endmodule
